FILE: rtl/core/ppid_pkg.sv
package ppid_pkg;

  localparam int MAX_POINTS_DEF = 1048576;
  localparam int COORD_BITS_DEF = 24;

  localparam int DIFF_W    = 25;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int RAD_W     = 52;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int DIST_W    = 25;
  localparam int LIMIT_W   = DIST_W + 2;
  localparam int SUM_W     = 46;
  localparam int TALLY_W   = 21;
  localparam int RATIO_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIFF_W-1:0] DIFF_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIOR_MEAN = 2'd0,
    CFG_SUM_ALL    = 2'd1
  } ppid_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_TALLY,
    ST_MEAN_GO,
    ST_MEAN,
    ST_RATIO_GO,
    ST_RATIO,
    ST_EMIT
  } ppid_state_t;

endpackage

FILE: rtl/core/ppid_in_if.sv
interface ppid_in_if #(
  parameter int COORD_BITS = ppid_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] model_x;
  logic signed [COORD_BITS-1:0] model_y;
  logic signed [COORD_BITS-1:0] model_z;
  logic                         model_valid;
  logic signed [COORD_BITS-1:0] ref_x;
  logic signed [COORD_BITS-1:0] ref_y;
  logic signed [COORD_BITS-1:0] ref_z;
  logic                         ref_valid;
  logic                         last_pair;

  modport source (
    output valid, model_x, model_y, model_z, model_valid,
    output ref_x, ref_y, ref_z, ref_valid, last_pair,
    input  ready
  );
  modport sink (
    input  valid, model_x, model_y, model_z, model_valid,
    input  ref_x, ref_y, ref_z, ref_valid, last_pair,
    output ready
  );
endinterface

FILE: rtl/core/ppid_out_if.sv
interface ppid_out_if;
  logic                            valid;
  logic                            ready;
  logic [ppid_pkg::DIST_W-1:0]     mean_distance;
  logic [ppid_pkg::RATIO_W-1:0]    inlier_ratio;
  logic [ppid_pkg::TALLY_W-1:0]    inlier_count;
  logic [ppid_pkg::TALLY_W-1:0]    counted_pairs;
  logic                            mean_saturated;

  modport source (
    output valid, mean_distance, inlier_ratio, inlier_count, counted_pairs, mean_saturated,
    input  ready
  );
  modport sink (
    input  valid, mean_distance, inlier_ratio, inlier_count, counted_pairs, mean_saturated,
    output ready
  );
endinterface

FILE: rtl/core/ppid_cfg_if.sv
interface ppid_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ppid_pkg::CFG_IDX_W-1:0] index;
  logic [ppid_pkg::DIST_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/point_pair_inlier_distance.sv
// channel   role     beat
// in_ch     sink     one point pair with valid flags and last marker
// out_ch    source   one cloud summary, only after a last pair
// cfg_ch    sink     register index and data, always ready
//
// pair with both points valid: squared differences summed, then the 26-step root recurrence
// pair without a distance: tallied directly; last pair adds two
// 46-step divisions on the shared divider, then the result register is loaded
// in_ch.ready is high only while idle; a pending result stalls the next summary in emit, and input with it
// rst_n is synchronous: clears state, tallies, sum, output valid and configuration registers
module point_pair_inlier_distance #(
  parameter int MAX_POINTS = ppid_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = ppid_pkg::COORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ppid_in_if.sink   in_ch,
  ppid_out_if.source out_ch,
  ppid_cfg_if.sink  cfg_ch
);
  import ppid_pkg::*;

  localparam int MAG_W     = (COORD_BITS + 1 > DIFF_W) ? COORD_BITS + 1 : DIFF_W;
  localparam int TALLY_MAX = (1 << TALLY_W) - 1;
  localparam int TALLY_CAP = (MAX_POINTS < TALLY_MAX) ? MAX_POINTS : TALLY_MAX;
  localparam logic [TALLY_W-1:0] CAP = TALLY_W'(TALLY_CAP);
  localparam logic [1:0] SQ_LAST = 2'd3;

  ppid_state_t state_r, state_nxt;

  logic [DIST_W-1:0]  prior_r;
  logic               sum_all_r;

  logic [DIFF_W-1:0]  diff_r [3];
  logic [DIFF_W-1:0]  diff_nxt [3];
  logic [DIFF_W-1:0]  diff_in [3];
  logic               have_dist_r, have_dist_nxt;
  logic               ref_ok_r, ref_ok_nxt;
  logic               last_r, last_nxt;
  logic [SQ_W-1:0]    prod_r, prod_nxt;
  logic [RAD_W-1:0]   sumsq_r, sumsq_nxt;
  logic [1:0]         sq_cnt_r, sq_cnt_nxt;
  logic [ROOT_W-1:0]  dist_r, dist_nxt;

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [TALLY_W-1:0] inlier_r, inlier_nxt;
  logic [TALLY_W-1:0] pair_r, pair_nxt;
  logic [DIST_W-1:0]  mean_r, mean_nxt;
  logic               sat_r, sat_nxt;
  logic [RATIO_W-1:0] ratio_r, ratio_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]  out_mean_r, out_mean_nxt;
  logic [RATIO_W-1:0] out_ratio_r, out_ratio_nxt;
  logic [TALLY_W-1:0] out_inlier_r, out_inlier_nxt;
  logic [TALLY_W-1:0] out_pair_r, out_pair_nxt;
  logic               out_sat_r, out_sat_nxt;

  logic signed [COORD_BITS-1:0] m_c [3];
  logic signed [COORD_BITS-1:0] r_c [3];
  logic signed [MAG_W:0]        dlt [3];
  logic [MAG_W:0]               mag [3];

  logic               in_ready;
  logic [DIFF_W-1:0]  sq_op;
  logic [SQ_W-1:0]    sq_prod;
  logic               sq_start, sq_done;
  logic [ROOT_W-1:0]  sq_root;
  logic               div_start, div_done;
  logic [SUM_W-1:0]   div_num, div_quo;
  logic [TALLY_W-1:0] div_den;

  logic [LIMIT_W-1:0] limit;
  logic               inlier;
  logic [DIST_W-1:0]  dist_clamp;
  logic [SUM_W:0]     sum_add;

  assign m_c[0] = in_ch.model_x;
  assign m_c[1] = in_ch.model_y;
  assign m_c[2] = in_ch.model_z;
  assign r_c[0] = in_ch.ref_x;
  assign r_c[1] = in_ch.ref_y;
  assign r_c[2] = in_ch.ref_z;

  // saturated absolute coordinate differences
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dlt[k]     = (MAG_W+1)'(m_c[k]) - (MAG_W+1)'(r_c[k]);
      mag[k]     = dlt[k][MAG_W] ? (MAG_W+1)'(-dlt[k]) : (MAG_W+1)'(dlt[k]);
      diff_in[k] = (mag[k] > (MAG_W+1)'(DIFF_MAX)) ? DIFF_MAX : mag[k][DIFF_W-1:0];
    end
  end

  // shared squarer
  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_op = diff_r[0];
      2'd1:    sq_op = diff_r[1];
      default: sq_op = diff_r[2];
    endcase
    sq_prod = SQ_W'(sq_op) * SQ_W'(sq_op);
  end

  always_comb begin
    limit      = LIMIT_W'({prior_r, 1'b0}) + LIMIT_W'(prior_r);
    inlier     = (LIMIT_W'(dist_r) < limit);
    dist_clamp = (dist_r > ROOT_W'(DIST_MAX)) ? DIST_MAX : dist_r[DIST_W-1:0];
    sum_add    = (SUM_W+1)'(sum_r) + (SUM_W+1)'(dist_clamp);
  end

  always_comb begin
    if (state_r == ST_RATIO_GO) begin
      div_num = SUM_W'({inlier_r, {FRAC_W{1'b0}}});
      div_den = pair_r;
    end else begin
      div_num = sum_r;
      div_den = inlier_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    sq_start       = 1'b0;
    div_start      = 1'b0;
    diff_nxt       = diff_r;
    have_dist_nxt  = have_dist_r;
    ref_ok_nxt     = ref_ok_r;
    last_nxt       = last_r;
    prod_nxt       = prod_r;
    sumsq_nxt      = sumsq_r;
    sq_cnt_nxt     = sq_cnt_r;
    dist_nxt       = dist_r;
    sum_nxt        = sum_r;
    inlier_nxt     = inlier_r;
    pair_nxt       = pair_r;
    mean_nxt       = mean_r;
    sat_nxt        = sat_r;
    ratio_nxt      = ratio_r;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;
    out_mean_nxt   = out_mean_r;
    out_ratio_nxt  = out_ratio_r;
    out_inlier_nxt = out_inlier_r;
    out_pair_nxt   = out_pair_r;
    out_sat_nxt    = out_sat_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          diff_nxt      = diff_in;
          have_dist_nxt = in_ch.model_valid & in_ch.ref_valid;
          ref_ok_nxt    = in_ch.ref_valid;
          last_nxt      = in_ch.last_pair;
          prod_nxt      = '0;
          sumsq_nxt     = '0;
          sq_cnt_nxt    = '0;
          state_nxt     = (in_ch.model_valid & in_ch.ref_valid) ? ST_SQUARE : ST_TALLY;
        end
      end
      ST_SQUARE: begin
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        sumsq_nxt  = sumsq_r + RAD_W'(prod_r);
        if (sq_cnt_r != SQ_LAST) begin
          prod_nxt = sq_prod;
        end else begin
          sq_start  = 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          dist_nxt  = sq_root;
          state_nxt = ST_TALLY;
        end
      end
      ST_TALLY: begin
        if (ref_ok_r && (pair_r < CAP)) begin
          pair_nxt = pair_r + 1'b1;
        end
        if (have_dist_r) begin
          if (inlier && (inlier_r < CAP)) begin
            inlier_nxt = inlier_r + 1'b1;
          end
          if (inlier || sum_all_r) begin
            sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          end
        end
        state_nxt = last_r ? ST_MEAN_GO : ST_IDLE;
      end
      ST_MEAN_GO: begin
        div_start = 1'b1;
        state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        if (div_done) begin
          if ((inlier_r == '0) || (pair_r == '0)) begin
            mean_nxt = DIST_MAX;
            sat_nxt  = 1'b1;
          end else begin
            mean_nxt = (div_quo > SUM_W'(DIST_MAX)) ? DIST_MAX : div_quo[DIST_W-1:0];
            sat_nxt  = 1'b0;
          end
          state_nxt = ST_RATIO_GO;
        end
      end
      ST_RATIO_GO: begin
        div_start = 1'b1;
        state_nxt = ST_RATIO;
      end
      ST_RATIO: begin
        if (div_done) begin
          ratio_nxt = (pair_r == '0) ? '0 : div_quo[RATIO_W-1:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_mean_nxt   = mean_r;
          out_ratio_nxt  = ratio_r;
          out_inlier_nxt = inlier_r;
          out_pair_nxt   = pair_r;
          out_sat_nxt    = sat_r;
          sum_nxt        = '0;
          inlier_nxt     = '0;
          pair_nxt       = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      inlier_r    <= '0;
      pair_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      inlier_r    <= inlier_nxt;
      pair_r      <= pair_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r       <= diff_nxt;
    have_dist_r  <= have_dist_nxt;
    ref_ok_r     <= ref_ok_nxt;
    last_r       <= last_nxt;
    prod_r       <= prod_nxt;
    sumsq_r      <= sumsq_nxt;
    sq_cnt_r     <= sq_cnt_nxt;
    dist_r       <= dist_nxt;
    mean_r       <= mean_nxt;
    sat_r        <= sat_nxt;
    ratio_r      <= ratio_nxt;
    out_mean_r   <= out_mean_nxt;
    out_ratio_r  <= out_ratio_nxt;
    out_inlier_r <= out_inlier_nxt;
    out_pair_r   <= out_pair_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r   <= '0;
      sum_all_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PRIOR_MEAN: prior_r   <= cfg_ch.data;
        CFG_SUM_ALL:    sum_all_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  ppid_isqrt #(
    .RAD_W (RAD_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sumsq_nxt),
    .done     (sq_done),
    .root     (sq_root)
  );

  ppid_div #(
    .NUM_W (SUM_W),
    .DEN_W (TALLY_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ch.ready           = in_ready;
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.mean_distance  = out_mean_r;
  assign out_ch.inlier_ratio   = out_ratio_r;
  assign out_ch.inlier_count   = out_inlier_r;
  assign out_ch.counted_pairs  = out_pair_r;
  assign out_ch.mean_saturated = out_sat_r;

  a_root_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == ST_ROOT))
    else $error("root finished outside root state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == ST_MEAN) || (state_r == ST_RATIO)))
    else $error("division finished outside division states");

  a_inliers_within_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    inlier_r <= pair_r)
    else $error("inlier tally above pair tally");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("ready again right after accepting a pair");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result raised outside emit state");

endmodule

FILE: rtl/core/ppid_isqrt.sv
module ppid_isqrt #(
  parameter int RAD_W = ppid_pkg::RAD_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RAD_W-1:0]   radicand,
  output logic               done,
  output logic [RAD_W/2-1:0] root
);
  localparam int ROOT_W = RAD_W / 2;
  localparam int CNT_W  = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;
  logic [ROOT_W+1:0] rem_step;

  // one root bit per cycle, two radicand bits brought down each step
  always_comb begin
    rem_sh   = {rem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rem_step = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNT_W'(ROOT_W - 1);
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_step;
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/core/ppid_div.sv
module ppid_div #(
  parameter int NUM_W = ppid_pkg::SUM_W,
  parameter int DEN_W = ppid_pkg::TALLY_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_diff;

  // restoring division, quotient bits shift in where dividend bits leave
  always_comb begin
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_diff = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

FILE: verif/point_pair_inlier_distance_tb.sv
module point_pair_inlier_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppid_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam longint unsigned TALLY_CAP =
    (MAX_POINTS_DEF < 2097151) ? MAX_POINTS_DEF : 2097151;
  localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 64'd1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RAND_PER_SETTING = 189;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic {ROW_SETTINGS, ROW_PAIR} row_kind_t;

  typedef struct {
    logic signed [CW-1:0] model_x;
    logic signed [CW-1:0] model_y;
    logic signed [CW-1:0] model_z;
    logic                 model_valid;
    logic signed [CW-1:0] ref_x;
    logic signed [CW-1:0] ref_y;
    logic signed [CW-1:0] ref_z;
    logic                 ref_valid;
    logic                 last_pair;
  } pair_t;

  typedef struct {
    logic [DIST_W-1:0]  mean_distance;
    logic [RATIO_W-1:0] inlier_ratio;
    logic [TALLY_W-1:0] inlier_count;
    logic [TALLY_W-1:0] counted_pairs;
    logic               mean_saturated;
  } summary_t;

  typedef struct {
    row_kind_t         kind;
    logic [DIST_W-1:0] prior;
    logic              sum_all;
    pair_t             pair;
    bit                typed;
    summary_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  ppid_in_if #(.COORD_BITS(CW)) in_ch();
  ppid_out_if out_ch();
  ppid_cfg_if cfg_ch();

  point_pair_inlier_distance #(
    .MAX_POINTS(MAX_POINTS_DEF),
    .COORD_BITS(CW)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  summary_t summary_q[$];
  stim_row_t directed[$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int stall_cycles = 0;

  logic [DIST_W-1:0]  prior_mean_cfg;
  logic               sum_all_cfg;
  logic [SUM_W-1:0]   acc_sum;
  logic [TALLY_W-1:0] acc_inliers;
  logic [TALLY_W-1:0] acc_pairs;

  function automatic pair_t mk_pair(logic signed [CW-1:0] mx, logic signed [CW-1:0] my,
                                    logic signed [CW-1:0] mz, logic mv,
                                    logic signed [CW-1:0] rx, logic signed [CW-1:0] ry,
                                    logic signed [CW-1:0] rz, logic rv, logic lp);
    pair_t p;
    p.model_x = mx;
    p.model_y = my;
    p.model_z = mz;
    p.model_valid = mv;
    p.ref_x = rx;
    p.ref_y = ry;
    p.ref_z = rz;
    p.ref_valid = rv;
    p.last_pair = lp;
    return p;
  endfunction

  function automatic summary_t mk_sum(logic [DIST_W-1:0] mean, logic [RATIO_W-1:0] ratio,
                                      logic [TALLY_W-1:0] inl, logic [TALLY_W-1:0] cnt,
                                      logic sat);
    summary_t s;
    s.mean_distance = mean;
    s.inlier_ratio = ratio;
    s.inlier_count = inl;
    s.counted_pairs = cnt;
    s.mean_saturated = sat;
    return s;
  endfunction

  task automatic add_settings(logic [DIST_W-1:0] prior, logic mode);
    stim_row_t r;
    r.kind = ROW_SETTINGS;
    r.prior = prior;
    r.sum_all = mode;
    r.typed = 1'b0;
    directed.insert(directed.size(), r);
  endtask

  task automatic add_pair(pair_t p);
    stim_row_t r;
    r.kind = ROW_PAIR;
    r.pair = p;
    r.typed = 1'b0;
    directed.insert(directed.size(), r);
  endtask

  task automatic add_pair_typed(pair_t p, summary_t w);
    stim_row_t r;
    r.kind = ROW_PAIR;
    r.pair = p;
    r.typed = 1'b1;
    r.want = w;
    directed.insert(directed.size(), r);
  endtask

  function automatic longint unsigned coord_delta(logic signed [CW-1:0] a,
                                                  logic signed [CW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    if (d > longint'(DIFF_MAX)) d = longint'(DIFF_MAX);
    return d;
  endfunction

  function automatic logic [DIST_W-1:0] pair_distance(pair_t p);
    longint unsigned ax, ay, az, rem, root, bitv;
    ax = coord_delta(p.model_x, p.ref_x);
    ay = coord_delta(p.model_y, p.ref_y);
    az = coord_delta(p.model_z, p.ref_z);
    rem = ax * ax + ay * ay + az * az;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (root > DIST_MAX) root = DIST_MAX;
    return root[DIST_W-1:0];
  endfunction

  task automatic predict_summary(input pair_t p, output bit emit, output summary_t s);
    longint unsigned pdist, total, mean, ratio;
    bit inlier;
    emit = 1'b0;
    if (p.ref_valid) begin
      if (p.model_valid) begin
        pdist = pair_distance(p);
        inlier = pdist < 3 * longint'(prior_mean_cfg);
        if (inlier || sum_all_cfg) begin
          total = acc_sum + pdist;
          if (total > SUM_CAP) total = SUM_CAP;
          acc_sum = total[SUM_W-1:0];
        end
        if (inlier && acc_inliers < TALLY_CAP) acc_inliers = acc_inliers + 1'b1;
      end
      if (acc_pairs < TALLY_CAP) acc_pairs = acc_pairs + 1'b1;
    end
    if (p.last_pair) begin
      emit = 1'b1;
      ratio = 0;
      if (acc_pairs == 0 || acc_inliers == 0) begin
        mean = DIST_MAX;
        s.mean_saturated = 1'b1;
      end else begin
        mean = acc_sum / acc_inliers;
        if (mean > DIST_MAX) mean = DIST_MAX;
        s.mean_saturated = 1'b0;
      end
      if (acc_pairs != 0) ratio = (longint'(acc_inliers) << FRAC_W) / acc_pairs;
      s.mean_distance = mean[DIST_W-1:0];
      s.inlier_ratio = ratio[RATIO_W-1:0];
      s.inlier_count = acc_inliers;
      s.counted_pairs = acc_pairs;
      acc_sum = '0;
      acc_inliers = '0;
      acc_pairs = '0;
    end
  endtask

  task automatic send_pair(pair_t p, bit typed, summary_t want);
    bit emit;
    summary_t s;
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.model_x <= p.model_x;
    in_ch.model_y <= p.model_y;
    in_ch.model_z <= p.model_z;
    in_ch.model_valid <= p.model_valid;
    in_ch.ref_x <= p.ref_x;
    in_ch.ref_y <= p.ref_y;
    in_ch.ref_z <= p.ref_z;
    in_ch.ref_valid <= p.ref_valid;
    in_ch.last_pair <= p.last_pair;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_summary(p, emit, s);
    if (emit) summary_q.insert(summary_q.size(), typed ? want : s);
  endtask

  task automatic write_reg(ppid_cfg_idx_t idx, logic [DIST_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_PRIOR_MEAN: prior_mean_cfg = value;
      CFG_SUM_ALL: sum_all_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [DIST_W-1:0] prior, logic mode);
    write_reg(CFG_PRIOR_MEAN, prior);
    write_reg(CFG_SUM_ALL, {{(DIST_W-1){1'b0}}, mode});
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for all summaries, then let any pair still in the datapath finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk) begin
    summary_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (summary_q.size() == 0) begin
        $error("summary beat with no expectation pending");
        errors++;
      end else begin
        want = summary_q.pop_front();
        if (out_ch.mean_distance !== want.mean_distance) begin
          $error("mean_distance: expected %0d, actual %0d",
                 want.mean_distance, out_ch.mean_distance);
          errors++;
        end
        if (out_ch.inlier_ratio !== want.inlier_ratio) begin
          $error("inlier_ratio: expected %0d, actual %0d",
                 want.inlier_ratio, out_ch.inlier_ratio);
          errors++;
        end
        if (out_ch.inlier_count !== want.inlier_count) begin
          $error("inlier_count: expected %0d, actual %0d",
                 want.inlier_count, out_ch.inlier_count);
          errors++;
        end
        if (out_ch.counted_pairs !== want.counted_pairs) begin
          $error("counted_pairs: expected %0d, actual %0d",
                 want.counted_pairs, out_ch.counted_pairs);
          errors++;
        end
        if (out_ch.mean_saturated !== want.mean_saturated) begin
          $error("mean_saturated: expected %0d, actual %0d",
                 want.mean_saturated, out_ch.mean_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("point_pair_inlier_distance_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    pair_t p;
    summary_t none;
    int sent, cloud_len, sc, span, sel;
    logic [DIST_W-1:0] prior;
    logic mode;

    in_ch.valid = 1'b0;
    in_ch.model_x = '0;
    in_ch.model_y = '0;
    in_ch.model_z = '0;
    in_ch.model_valid = 1'b0;
    in_ch.ref_x = '0;
    in_ch.ref_y = '0;
    in_ch.ref_z = '0;
    in_ch.ref_valid = 1'b0;
    in_ch.last_pair = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_PRIOR_MEAN;
    cfg_ch.data = '0;
    prior_mean_cfg = '0;
    sum_all_cfg = 1'b0;
    acc_sum = '0;
    acc_inliers = '0;
    acc_pairs = '0;
    none = mk_sum('0, '0, '0, '0, 1'b0);

    // reset values: limit zero, nothing is an inlier
    add_pair_typed(mk_pair(C_MAX, 0, C_MIN, 1, 0, 0, 0, 0, 1),
                   mk_sum(DIST_MAX, 0, 0, 0, 1));
    add_pair(mk_pair(C_MAX, C_MAX, C_MAX, 1, C_MIN, C_MIN, C_MIN, 1, 0));
    add_pair_typed(mk_pair(5, 6, 7, 0, -5, -6, -7, 1, 1),
                   mk_sum(DIST_MAX, 0, 0, 2, 1));
    add_settings(DIST_MAX, 1'b0);
    add_pair(mk_pair(C_MIN, C_MIN, C_MIN, 1, C_MAX, C_MAX, C_MAX, 1, 1));
    add_pair_typed(mk_pair(C_MIN, C_MAX, 123, 1, C_MIN, C_MAX, 123, 1, 1),
                   mk_sum(0, 65536, 1, 1, 0));
    add_pair(mk_pair(100, 200, 300, 0, 0, 0, 0, 1, 0));
    add_pair(mk_pair(1000, -2000, 3000, 1, -1000, 2000, -3000, 1, 0));
    add_pair(mk_pair(C_MAX, C_MAX, C_MAX, 1, C_MIN, C_MIN, C_MIN, 0, 0));
    add_pair(mk_pair(-77, 88, -99, 1, -77, 88, -99, 1, 1));
    // sum-all with a tiny limit: outliers push the mean past its range
    add_settings(1, 1'b1);
    add_pair(mk_pair(C_MAX, C_MAX, C_MAX, 1, C_MIN, C_MIN, C_MIN, 1, 0));
    add_pair(mk_pair(C_MIN, C_MIN, C_MIN, 1, C_MAX, C_MAX, C_MAX, 1, 0));
    add_pair(mk_pair(0, 0, 0, 1, 0, 0, 0, 1, 1));
    add_pair(mk_pair(3, 0, 0, 1, 0, 0, 0, 1, 0));
    add_pair(mk_pair(2, 0, 0, 1, 0, 0, 0, 1, 0));
    add_pair(mk_pair(0, -2, 0, 1, 0, 0, 0, 1, 1));
    add_settings(0, 1'b1);
    add_pair_typed(mk_pair(10, 20, 30, 1, 40, 50, 60, 1, 1),
                   mk_sum(DIST_MAX, 0, 0, 1, 1));
    add_settings(25'h1000, 1'b0);
    add_pair(mk_pair(0, 0, 0, 1, 0, 0, 24'h2FFF, 1, 0));
    add_pair(mk_pair(0, 0, 0, 1, 0, 0, 24'h3000, 1, 0));
    add_pair(mk_pair(1, 2, 3, 0, 4, 5, 6, 0, 0));
    add_pair(mk_pair(-500, 0, 0, 1, 0, 0, 0, 1, 1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_SETTINGS) begin
        settle();
        apply_settings(directed[i].prior, directed[i].sum_all);
      end else begin
        send_pair(directed[i].pair, directed[i].typed, directed[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 9 : (ph == 1) ? 53 : 0;
      rcv_idle = (ph == 0) ? 53 : (ph == 1) ? 9 : 0;
      for (int st = 0; st < 3; st++) begin
        sel = ph * 3 + st;
        sc = $urandom_range(2, 20);
        case (sel % 4)
          0: prior = '0;
          1: prior = DIST_MAX;
          default: prior = DIST_W'($urandom_range(0, 1 << sc));
        endcase
        mode = (sel % 2 == 1);
        settle();
        apply_settings(prior, mode);
        sent = 0;
        span = 1 << (sc + 1);
        while (sent < RAND_PER_SETTING) begin
          cloud_len = ($urandom_range(19) == 0) ? $urandom_range(25, 120)
                                                : $urandom_range(1, 16);
          for (int k = 0; k < cloud_len; k++) begin
            p.model_x = CW'($urandom());
            p.model_y = CW'($urandom());
            p.model_z = CW'($urandom());
            if ($urandom_range(9) < 2) begin
              p.ref_x = CW'($urandom());
              p.ref_y = CW'($urandom());
              p.ref_z = CW'($urandom());
            end else begin
              p.ref_x = p.model_x + CW'($urandom_range(0, 2 * span) - span);
              p.ref_y = p.model_y + CW'($urandom_range(0, 2 * span) - span);
              p.ref_z = p.model_z + CW'($urandom_range(0, 2 * span) - span);
            end
            p.model_valid = ($urandom_range(99) >= 12);
            p.ref_valid = ($urandom_range(99) >= 10);
            p.last_pair = (k == cloud_len - 1);
            send_pair(p, 1'b0, none);
            sent++;
          end
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("point_pair_inlier_distance_tb: PASS");
    end else begin
      $display("point_pair_inlier_distance_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ppid_pkg.sv
rtl/core/ppid_in_if.sv
rtl/core/ppid_out_if.sv
rtl/core/ppid_cfg_if.sv
rtl/core/ppid_isqrt.sv
rtl/core/ppid_div.sv
rtl/core/point_pair_inlier_distance.sv
verif/point_pair_inlier_distance_tb.sv
